// ----- rtl/tblt_pkg.sv -----
`default_nettype none

package tblt_pkg;

  localparam logic [2:0] OP_LOOKUP     = 3'd0;
  localparam logic [2:0] OP_INSERT     = 3'd1;
  localparam logic [2:0] OP_REMOVE     = 3'd2;
  localparam logic [2:0] OP_INVALIDATE = 3'd3;
  localparam logic [2:0] OP_FLUSH      = 3'd4;

  localparam logic [15:0] LEN_MAX   = 16'hffff;
  localparam logic [8:0]  COUNT_MAX = 9'h1ff;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] address;
    logic [15:0] handle;
    logic [31:0] length;
  } req_word_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] found_handle;
    logic [8:0]  dropped_count;
  } rsp_word_t;

  function automatic logic [31:0] fold(input logic [31:0] a);
    logic [31:0] h;
    h = a ^ (a >> 16);
    h = h ^ (h >> 8);
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/translated_block_lookup_table.sv -----
`default_nettype none

// Direct-mapped table of translated code blocks held in one memory with a write port and a
// registered read port, driven by a small sequencer. After reset the table is cleared by a
// sweep over all TABLE_ENTRIES entries during which no word is accepted. Per word: lookup
// and remove read the indexed entry and then load the result, insert writes the entry when
// the word is accepted, flush runs the same clearing sweep, and invalidate range reads every
// entry once through the read port and checks it with one add-and-compare unit. A new word
// is accepted as soon as the sequencer is idle, even while the previous result still waits
// in the output register.

module translated_block_lookup_table #(
  parameter int TABLE_ENTRIES = 256,
  parameter int HANDLE_BITS   = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire tblt_pkg::req_word_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output tblt_pkg::rsp_word_t      rsp
);

  localparam int IDX_BITS = $clog2(TABLE_ENTRIES);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic                   valid;
    logic [31:0]            tag;
    logic [HANDLE_BITS-1:0] handle;
    logic [15:0]            length;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data;

  logic [2:0]          state;
  logic [IDX_BITS-1:0] ptr;
  logic [IDX_BITS-1:0] idx;
  logic [IDX_BITS-1:0] scan_idx;
  logic                scan_iss;
  logic                scan_pend;
  logic                flushing;
  logic [2:0]          op;
  logic [31:0]         addr;
  logic [31:0]         end_addr;
  logic [8:0]          count;
  tblt_pkg::rsp_word_t res;

  logic                accept;
  logic                rsp_load;
  logic [31:0]         req_hash;
  logic [IDX_BITS-1:0] req_idx;
  logic [IDX_BITS-1:0] rd_addr;
  logic                wr_en;
  logic [IDX_BITS-1:0] wr_addr;
  entry_t              wr_data;
  logic [31:0]         scan_bend;
  logic                scan_hit;
  logic                lk_hit;
  logic                rm_hit;
  logic [15:0]         len_sat;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);
  assign req_hash  = tblt_pkg::fold(req.address);
  assign req_idx   = req_hash[IDX_BITS-1:0];
  assign len_sat   = (req.length > 32'(tblt_pkg::LEN_MAX)) ? tblt_pkg::LEN_MAX
                                                            : req.length[15:0];

  assign scan_bend = rd_data.tag + 32'(rd_data.length);
  assign scan_hit  = scan_pend && rd_data.valid && (rd_data.tag < end_addr) &&
                     (scan_bend > addr);
  assign lk_hit    = rd_data.valid && (rd_data.tag == addr);
  assign rm_hit    = (rd_data.tag == addr);

  always_comb begin
    case (state)
      ST_IDLE: rd_addr = req_idx;
      ST_SCAN: rd_addr = ptr;
      default: rd_addr = idx;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr;
      end
      ST_IDLE: begin
        if (accept && req.operation == tblt_pkg::OP_INSERT) begin
          wr_en          = 1'b1;
          wr_addr        = req_idx;
          wr_data.valid  = 1'b1;
          wr_data.tag    = req.address;
          wr_data.handle = HANDLE_BITS'(req.handle);
          wr_data.length = len_sat;
        end
      end
      ST_READ: begin
        wr_en = (op == tblt_pkg::OP_REMOVE) && rm_hit;
      end
      ST_SCAN: begin
        wr_en   = scan_hit;
        wr_addr = scan_idx;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      ptr       <= '0;
      scan_iss  <= 1'b0;
      scan_pend <= 1'b0;
      flushing  <= 1'b0;
      count     <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == IDX_LAST) begin
            state    <= flushing ? ST_DONE : ST_IDLE;
            flushing <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op       <= req.operation;
            addr     <= req.address;
            idx      <= req_idx;
            end_addr <= req.address + req.length;
            res      <= '0;
            count    <= '0;
            ptr      <= '0;
            case (req.operation)
              tblt_pkg::OP_LOOKUP, tblt_pkg::OP_REMOVE: state <= ST_READ;
              tblt_pkg::OP_INVALIDATE: begin
                state     <= ST_SCAN;
                scan_iss  <= 1'b1;
                scan_pend <= 1'b0;
              end
              tblt_pkg::OP_FLUSH: begin
                state    <= ST_CLEAR;
                flushing <= 1'b1;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_READ: begin
          if (op == tblt_pkg::OP_LOOKUP) begin
            res.hit          <= lk_hit;
            res.found_handle <= lk_hit ? 16'(rd_data.handle) : 16'd0;
          end
          state <= ST_DONE;
        end
        ST_SCAN: begin
          scan_pend <= scan_iss;
          scan_idx  <= ptr;
          if (scan_iss) begin
            ptr <= ptr + 1'b1;
            if (ptr == IDX_LAST) begin
              scan_iss <= 1'b0;
            end
          end
          if (scan_hit && count != tblt_pkg::COUNT_MAX) begin
            count <= count + 1'b1;
          end
          if (!scan_iss && !scan_pend) begin
            res.dropped_count <= count;
            state             <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  a_reset_sweep: assert property (@(posedge clk) rst |=> state == ST_CLEAR)
    else $error("reset did not start the clearing sweep");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && !scan_iss && !scan_pend |=> state == ST_DONE)
    else $error("invalidate scan did not finish");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= TABLE_ENTRIES)
    else $error("drop count exceeds table size");

  a_rsp_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> rsp.dropped_count == 9'd0)
    else $error("hit and drop count both set");

  a_miss_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_load && !res.hit |-> res.found_handle == 16'd0)
    else $error("handle reported on a miss");

endmodule

`default_nettype wire

// ----- sim/tb_translated_block_lookup_table.sv -----
`default_nettype none

module tb_translated_block_lookup_table;

  localparam int TABLE_ENTRIES = 256;
  localparam int HANDLE_BITS   = 16;
  localparam int RANDOM_WORDS  = 1400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int LONG_HOLD     = 400;

  localparam logic [2:0] OP_SPARE0 = 3'd5;
  localparam logic [2:0] OP_SPARE1 = 3'd6;
  localparam logic [2:0] OP_SPARE2 = 3'd7;

  // shadow copy of the block table and the queue of responses it predicts
  class block_table_board;
    bit [31:0] tags[TABLE_ENTRIES];
    bit [15:0] handles[TABLE_ENTRIES];
    bit [15:0] spans[TABLE_ENTRIES];
    bit        live[TABLE_ENTRIES];
    tblt_pkg::rsp_word_t awaited[$];
    int        errors;

    function void wipe(int unsigned slot);
      tags[slot]    = '0;
      handles[slot] = '0;
      spans[slot]   = '0;
      live[slot]    = 1'b0;
    endfunction

    function void note_request(tblt_pkg::req_word_t w);
      tblt_pkg::rsp_word_t e;
      bit [31:0]   h;
      bit [31:0]   top;
      bit [31:0]   bend;
      int unsigned slot;
      int unsigned dropped;
      e = '0;
      h = w.address ^ (w.address >> 16);
      h = h ^ (h >> 8);
      slot = h & (TABLE_ENTRIES - 1);
      case (w.operation)
        tblt_pkg::OP_LOOKUP: begin
          if (live[slot] && tags[slot] == w.address) begin
            e.hit = 1'b1;
            e.found_handle = handles[slot];
          end
        end
        tblt_pkg::OP_INSERT: begin
          tags[slot]    = w.address;
          handles[slot] = w.handle;
          spans[slot]   = (w.length > tblt_pkg::LEN_MAX) ? tblt_pkg::LEN_MAX : w.length[15:0];
          live[slot]    = 1'b1;
        end
        tblt_pkg::OP_REMOVE: begin
          if (tags[slot] == w.address) wipe(slot);
        end
        tblt_pkg::OP_INVALIDATE: begin
          top = w.address + w.length;
          dropped = 0;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            bend = tags[i] + {16'h0, spans[i]};
            if (live[i] && tags[i] < top && bend > w.address) begin
              wipe(i);
              if (dropped < tblt_pkg::COUNT_MAX) dropped++;
            end
          end
          e.dropped_count = dropped[8:0];
        end
        tblt_pkg::OP_FLUSH: begin
          for (int i = 0; i < TABLE_ENTRIES; i++) wipe(i);
        end
        default: ;
      endcase
      awaited.push_back(e);
    endfunction

    function void check_response(tblt_pkg::rsp_word_t r);
      tblt_pkg::rsp_word_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response word: hit=%0d handle=%h dropped=%0d",
                                   r.hit, r.found_handle, r.dropped_count);
      end else begin
        e = awaited.pop_front();
        if (r.hit !== e.hit || r.found_handle !== e.found_handle ||
            r.dropped_count !== e.dropped_count) begin
          errors++;
          if (errors <= 10)
            $display({"response mismatch: expected hit=%0d handle=%h dropped=%0d, ",
                      "got hit=%0d handle=%h dropped=%0d"},
                     e.hit, e.found_handle, e.dropped_count,
                     r.hit, r.found_handle, r.dropped_count);
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  tblt_pkg::req_word_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  tblt_pkg::rsp_word_t rsp;

  block_table_board board;
  int        idle_cycles = 0;
  bit        hold_off_rx = 1'b0;
  bit [31:0] hot_addr[16];

  translated_block_lookup_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .HANDLE_BITS  (HANDLE_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [31:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return hot_addr[$urandom_range(0, 15)];
    if (r < 65) return hot_addr[$urandom_range(0, 15)] + $urandom_range(0, 64);
    if (r < 72) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hffff_ffff;
        2: return 32'h8000_0000;
        default: return 32'h7fff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic tblt_pkg::req_word_t random_word();
    tblt_pkg::req_word_t w;
    int unsigned r;
    w.address = pick_addr();
    w.handle  = 16'($urandom);
    w.length  = $urandom;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      w.operation = tblt_pkg::OP_LOOKUP;
    end else if (r < 65) begin
      w.operation = tblt_pkg::OP_INSERT;
      r = $urandom_range(0, 99);
      if (r < 50) w.length = $urandom_range(1, 256);
      else if (r < 75) w.length = $urandom_range(0, 65535);
      else if (r < 85) begin
        case ($urandom_range(0, 3))
          0: w.length = 32'h0000_ffff;
          1: w.length = 32'h0001_0000;
          2: w.length = 32'h0000_0000;
          default: w.length = 32'hffff_ffff;
        endcase
      end
    end else if (r < 77) begin
      w.operation = tblt_pkg::OP_REMOVE;
    end else if (r < 87) begin
      w.operation = tblt_pkg::OP_INVALIDATE;
      r = $urandom_range(0, 99);
      if (r < 40) w.length = $urandom_range(0, 64);
      else if (r < 70) w.length = $urandom_range(0, 4096);
      else if (r < 85) begin
        case ($urandom_range(0, 2))
          0: w.length = 32'h0000_0000;
          1: w.length = 32'hffff_ffff;
          default: w.length = 32'h8000_0000;
        endcase
      end
    end else if (r < 89) begin
      w.operation = tblt_pkg::OP_FLUSH;
    end else if (r < 92) begin
      case ($urandom_range(0, 2))
        0: w.operation = OP_SPARE0;
        1: w.operation = OP_SPARE1;
        default: w.operation = OP_SPARE2;
      endcase
    end else begin
      w.operation = tblt_pkg::OP_LOOKUP;
    end
    return w;
  endfunction

  task automatic send_word(input tblt_pkg::req_word_t w, input int unsigned gap);
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put(input logic [2:0] op, input logic [31:0] addr,
                     input logic [15:0] hnd, input logic [31:0] len);
    tblt_pkg::req_word_t w;
    w.operation = op;
    w.address   = addr;
    w.handle    = hnd;
    w.length    = len;
    send_word(w, pick_gap());
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) board.check_response(rsp);
      if (req_valid && !req_stall) board.note_request(req);
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, quiet stretches, one long hold-off on request
  initial begin
    int unsigned n;
    rsp_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_rx) begin
        hold_off_rx = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        n = pick_gap();
        if (n > 0) begin
          rsp_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("** translated_block_lookup_table: FAILED **");
    $finish;
  end

  initial begin
    bit steady;
    bit [7:0] b;
    board = new();
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty table, tag zero on a cleared entry
    put(tblt_pkg::OP_LOOKUP,     32'h0000_0000, 16'h0000, 32'h0000_0000);
    put(tblt_pkg::OP_REMOVE,     32'h0000_0000, 16'h0000, 32'h0000_0000);
    put(tblt_pkg::OP_INSERT,     32'h0000_0000, 16'hffff, 32'h0000_0000);
    put(tblt_pkg::OP_LOOKUP,     32'h0000_0000, 16'h0000, 32'h0000_0000);
    // same slot as address zero, length saturates
    put(tblt_pkg::OP_INSERT,     32'hffff_ffff, 16'h0000, 32'hffff_ffff);
    put(tblt_pkg::OP_LOOKUP,     32'hffff_ffff, 16'h1234, 32'h0000_0000);
    put(tblt_pkg::OP_LOOKUP,     32'h0000_0000, 16'h0000, 32'h0000_0000);
    put(tblt_pkg::OP_INSERT,     32'h1234_5678, 16'h1234, 32'h0000_ffff);
    put(tblt_pkg::OP_INSERT,     32'h0000_1000, 16'habcd, 32'h0001_0000);
    // remove with a colliding but different tag leaves the entry
    put(tblt_pkg::OP_REMOVE,     32'h1235_5778, 16'h0000, 32'h0000_0000);
    put(tblt_pkg::OP_LOOKUP,     32'h1234_5678, 16'h0000, 32'h0000_0000);
    put(tblt_pkg::OP_REMOVE,     32'h1234_5678, 16'h0000, 32'h0000_0000);
    put(tblt_pkg::OP_LOOKUP,     32'h1234_5678, 16'h0000, 32'h0000_0000);
    put(tblt_pkg::OP_INSERT,     32'h8000_0000, 16'h0005, 32'h0000_0010);
    put(tblt_pkg::OP_INVALIDATE, 32'h8000_0008, 16'h0000, 32'h0000_0001);
    // zero-length range inside a block
    put(tblt_pkg::OP_INVALIDATE, 32'h0000_1001, 16'h0000, 32'h0000_0000);
    // a wrapping range, then a range over nearly all addresses
    put(tblt_pkg::OP_INVALIDATE, 32'hffff_0000, 16'h0000, 32'h0002_0000);
    put(tblt_pkg::OP_INSERT,     32'h0000_0040, 16'h0007, 32'h0000_0020);
    put(tblt_pkg::OP_INVALIDATE, 32'h0000_0000, 16'h0000, 32'hffff_ffff);
    put(OP_SPARE0,               32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    put(OP_SPARE1,               32'h0000_0000, 16'h0000, 32'h0000_0000);
    put(OP_SPARE2,               32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    put(tblt_pkg::OP_FLUSH,      32'h0000_0000, 16'h0000, 32'h0000_0000);
    put(tblt_pkg::OP_LOOKUP,     32'hffff_ffff, 16'h0000, 32'h0000_0000);

    steady = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 300 == 0) begin
        // half the pool shares a slot with the other half
        for (int i = 0; i < 8; i++) begin
          b = 8'($urandom_range(1, 255));
          hot_addr[i]     = $urandom;
          hot_addr[i + 8] = hot_addr[i] ^ {16'h0, b, b};
        end
      end
      if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == 500) hold_off_rx = 1'b1;
      if (n == 900) drain();
      send_word(random_word(), steady ? 0 : pick_gap());
    end

    drain();
    repeat (TABLE_ENTRIES + 16) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** translated_block_lookup_table: PASSED **");
    end else begin
      $display("** translated_block_lookup_table: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
